### rtl/core/hba_pkg.sv
package hba_pkg;

    localparam int HEAP_WORDS   = 4096;
    localparam int HEADER_WORDS = 3;
    localparam int ADDR_W       = 12;
    localparam int SIZE_W       = 13;
    localparam int TOP_W        = 13;
    localparam int SUM_W        = 14;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam logic [2:0] REG_FIT_POLICY = 3'd0;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
        logic [ADDR_W-1:0] prev;
    } t_hdr;

endpackage

### rtl/core/heap_block_allocator.sv
// an allocate walks the block headers in order, reading and then evaluating each one;
// a free walks the same way and then merges the freed block with free neighbours
// throughput: one item at a time; the next may be accepted while a result waits
// reset: synchronous active low, heap emptied (top mark to zero), fit policy to first fit
// header memory needs no clearing: only written headers are ever read
module heap_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // action, request_words, block_address, zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // granted_address, status, zero fill
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam logic [hba_pkg::SUM_W-1:0] HDR = hba_pkg::SUM_W'(hba_pkg::HEADER_WORDS);
    localparam logic [hba_pkg::SUM_W-1:0] HEAP = hba_pkg::SUM_W'(hba_pkg::HEAP_WORDS);

    typedef enum logic [3:0] {
        S_IDLE, S_WRD, S_WEV, S_AEND, S_SPLIT, S_RLRD, S_RLWR,
        S_FNRD, S_FNEV, S_FWH, S_FPRD, S_FPEV, S_OUT
    } t_state;

    hba_pkg::t_hdr mem [hba_pkg::HEAP_WORDS];
    hba_pkg::t_hdr r_rdata;
    logic [hba_pkg::ADDR_W-1:0] mem_raddr, mem_waddr;
    hba_pkg::t_hdr mem_wdata;
    logic mem_we;

    t_state r_state;
    logic r_policy, r_act, r_found, r_ov, r_st, r_ost;
    logic [hba_pkg::SIZE_W-1:0] r_req, r_bsize, r_fsize;
    logic [hba_pkg::ADDR_W-1:0] r_h, r_tgt, r_best, r_bprev, r_last, r_fprev, r_rlt, r_rlv;
    logic [hba_pkg::ADDR_W-1:0] r_gr, r_ogr;
    logic [hba_pkg::TOP_W-1:0] r_top;
    t_state r_ret;

    logic [hba_pkg::SUM_W-1:0] nh, nsz, ntop, bnext, rpos, fsum, psum;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign nh    = {2'b0, r_h} + HDR + {1'b0, r_rdata.size};
    assign bnext = {2'b0, r_best} + HDR + {1'b0, r_bsize};
    assign rpos  = {2'b0, r_best} + HDR + {1'b0, r_req};
    assign ntop  = {1'b0, r_top} + HDR + {1'b0, r_req};
    assign nsz   = {1'b0, r_bsize} - {1'b0, r_req};
    assign fsum  = {1'b0, r_fsize} + HDR + {1'b0, r_rdata.size};
    assign psum  = {1'b0, r_rdata.size} + HDR + {1'b0, r_fsize};

    always_comb begin
        mem_raddr = r_h;
        mem_we    = 1'b0;
        mem_waddr = r_h;
        mem_wdata = r_rdata;
        unique case (r_state)
            S_FNRD:  mem_raddr = hba_pkg::ADDR_W'({2'b0, r_h} + HDR + {1'b0, r_fsize});
            S_FPRD:  mem_raddr = r_fprev;
            S_RLRD:  mem_raddr = r_rlt;
            S_RLWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_rlt;
                mem_wdata = '{size: r_rdata.size, free: r_rdata.free, prev: r_rlv};
            end
            S_AEND: begin
                mem_we = 1'b1;
                if (r_found) begin
                    mem_waddr = r_best;
                    mem_wdata = '{size: (nsz >= HDR + hba_pkg::SUM_W'(1)) ? r_req : r_bsize,
                                  free: 1'b0, prev: r_bprev};
                end else begin
                    mem_we    = (ntop <= HEAP);
                    mem_waddr = r_top[hba_pkg::ADDR_W-1:0];
                    mem_wdata = '{size: r_req, free: 1'b0, prev: r_last};
                end
            end
            S_SPLIT: begin
                mem_we    = 1'b1;
                mem_waddr = rpos[hba_pkg::ADDR_W-1:0];
                mem_wdata = '{size: hba_pkg::SIZE_W'(nsz - HDR), free: 1'b1, prev: r_best};
            end
            S_FWH: begin
                mem_we    = 1'b1;
                mem_waddr = r_h;
                mem_wdata = '{size: r_fsize, free: 1'b1, prev: r_fprev};
            end
            S_FPEV: begin
                mem_we    = r_rdata.free;
                mem_waddr = r_fprev;
                mem_wdata = '{size: hba_pkg::SIZE_W'(psum), free: 1'b1, prev: r_rdata.prev};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= hba_pkg::FIT_FIRST;
            r_top    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_paddr == hba_pkg::REG_FIT_POLICY) begin
                r_policy <= i_pwdata[0];
            end
            if (r_state == S_OUT && (!r_ov || i_m_tready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_act   <= i_s_tdata[0];
                        r_req   <= i_s_tdata[13:1];
                        r_tgt   <= i_s_tdata[25:14] - hba_pkg::ADDR_W'(hba_pkg::HEADER_WORDS);
                        r_h     <= '0;
                        r_found <= 1'b0;
                        r_last  <= '0;
                        r_gr    <= '0;
                        r_st    <= hba_pkg::ST_DONE;
                        if (i_s_tdata[0] == hba_pkg::ACT_ALLOC) begin
                            r_state <= (r_top == '0) ? S_AEND : S_WRD;
                        end else if (i_s_tdata[25:14] < hba_pkg::ADDR_W'(hba_pkg::HEADER_WORDS)
                                     || r_top == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WRD;
                        end
                    end
                end
                S_WRD: r_state <= S_WEV;
                S_WEV: begin
                    if (r_act == hba_pkg::ACT_ALLOC) begin
                        r_h    <= nh[hba_pkg::ADDR_W-1:0];
                        r_last <= r_h;
                        if (nh >= {1'b0, r_top}) begin
                            r_state <= S_AEND;
                        end else begin
                            r_state <= S_WRD;
                        end
                        if (r_rdata.free && r_rdata.size >= r_req &&
                            (!r_found || (r_policy == hba_pkg::FIT_BEST &&
                                          r_rdata.size < r_bsize))) begin
                            r_best  <= r_h;
                            r_bsize <= r_rdata.size;
                            r_bprev <= r_rdata.prev;
                            r_found <= 1'b1;
                            if (r_policy == hba_pkg::FIT_FIRST) begin
                                r_state <= S_AEND;
                            end
                        end
                    end else if (r_h == r_tgt) begin
                        r_fsize <= r_rdata.size;
                        r_fprev <= r_rdata.prev;
                        if (r_rdata.free) begin
                            r_state <= S_OUT;
                        end else if (nh < {1'b0, r_top}) begin
                            r_state <= S_FNRD;
                        end else begin
                            r_state <= S_FWH;
                        end
                    end else if (r_h > r_tgt || nh >= {1'b0, r_top}) begin
                        r_state <= S_OUT;
                    end else begin
                        r_h     <= nh[hba_pkg::ADDR_W-1:0];
                        r_state <= S_WRD;
                    end
                end
                S_AEND: begin
                    if (r_found) begin
                        r_gr    <= hba_pkg::ADDR_W'({2'b0, r_best} + HDR);
                        r_state <= (nsz >= HDR + hba_pkg::SUM_W'(1)) ? S_SPLIT : S_OUT;
                    end else if (ntop > HEAP) begin
                        r_st    <= hba_pkg::ST_FAIL;
                        r_state <= S_OUT;
                    end else begin
                        r_gr    <= hba_pkg::ADDR_W'({1'b0, r_top} + HDR);
                        r_top   <= hba_pkg::TOP_W'(ntop);
                        r_state <= S_OUT;
                    end
                end
                S_SPLIT: begin
                    r_rlt <= bnext[hba_pkg::ADDR_W-1:0];
                    r_rlv <= rpos[hba_pkg::ADDR_W-1:0];
                    r_ret <= S_OUT;
                    r_state <= (bnext < {1'b0, r_top}) ? S_RLRD : S_OUT;
                end
                S_RLRD: r_state <= S_RLWR;
                S_RLWR: r_state <= r_ret;
                S_FNRD: r_state <= S_FNEV;
                S_FNEV: begin
                    r_state <= S_FWH;
                    if (r_rdata.free) begin
                        r_fsize <= hba_pkg::SIZE_W'(fsum);
                        r_rlt   <= hba_pkg::ADDR_W'({2'b0, r_h} + HDR + fsum);
                        r_rlv   <= r_h;
                        r_ret   <= S_FWH;
                        if ({2'b0, r_h} + HDR + fsum < {1'b0, r_top}) begin
                            r_state <= S_RLRD;
                        end
                    end
                end
                S_FWH: r_state <= (r_h != '0) ? S_FPRD : S_OUT;
                S_FPRD: r_state <= S_FPEV;
                S_FPEV: begin
                    r_state <= S_OUT;
                    if (r_rdata.free) begin
                        r_rlt <= hba_pkg::ADDR_W'({2'b0, r_fprev} + HDR + psum);
                        r_rlv <= r_fprev;
                        r_ret <= S_OUT;
                        if ({2'b0, r_fprev} + HDR + psum < {1'b0, r_top}) begin
                            r_state <= S_RLRD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_m_tready) begin
                        r_ogr   <= r_gr;
                        r_ost   <= r_st;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b0, r_ost, r_ogr};
    assign o_prdata   = {31'b0, r_policy};
    assign o_pready   = 1'b1;

`ifndef SYNTHESIS
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_top} <= HEAP)
        else $error("heap top beyond heap");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_m_tready |=> r_ov && $stable(o_m_tdata))
        else $error("result lost while stalled");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ost == hba_pkg::ST_FAIL |-> r_ogr == '0)
        else $error("failed allocate with address");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == S_IDLE)
        else $error("accept while busy");
`endif

endmodule

### tb/sv/hba_checker.sv
module hba_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [hba_pkg::ADDR_W-1:0] granted;
        logic                       status;
    } t_grant;

    int   blk_size [hba_pkg::HEAP_WORDS];
    bit   blk_free [hba_pkg::HEAP_WORDS];
    int   blk_prev [hba_pkg::HEAP_WORDS];
    int   top_mark;
    logic policy;
    t_grant grants_due[$];

    initial begin
        o_errors  = 0;
        o_results = 0;
        top_mark  = 0;
        policy    = hba_pkg::FIT_FIRST;
    end

    assign o_pending = grants_due.size();

    function automatic int next_hdr(int h);
        return h + hba_pkg::HEADER_WORDS + blk_size[h];
    endfunction

    function automatic void relink(int h);
        int n;
        n = next_hdr(h);
        if (n < top_mark && n < hba_pkg::HEAP_WORDS) blk_prev[n] = h;
    endfunction

    function automatic bit is_live(int target);
        int h;
        h = 0;
        while (h < top_mark && h < hba_pkg::HEAP_WORDS) begin
            if (h == target) return !blk_free[h];
            if (h > target) return 0;
            h = next_hdr(h);
        end
        return 0;
    endfunction

    function automatic void release_block(int addr);
        int h, n, p;
        if (addr < hba_pkg::HEADER_WORDS) return;
        h = addr - hba_pkg::HEADER_WORDS;
        if (!is_live(h)) return;
        blk_free[h] = 1;
        n = next_hdr(h);
        if (n < top_mark && n < hba_pkg::HEAP_WORDS && blk_free[n]) begin
            blk_size[h] += hba_pkg::HEADER_WORDS + blk_size[n];
            relink(h);
        end
        if (h != 0) begin
            p = blk_prev[h];
            if (p < hba_pkg::HEAP_WORDS && blk_free[p]) begin
                blk_size[p] += hba_pkg::HEADER_WORDS + blk_size[h];
                relink(p);
            end
        end
    endfunction

    function automatic t_grant claim_block(int req);
        int h, last, best, best_sz, sz, r;
        bit found;
        t_grant g;
        h = 0; last = 0; best = 0; best_sz = 0; found = 0;
        g = '0;
        while (h < top_mark && h < hba_pkg::HEAP_WORDS) begin
            sz = blk_size[h];
            if (blk_free[h] && sz >= req) begin
                if (!found || (policy == hba_pkg::FIT_BEST && sz < best_sz)) begin
                    best = h;
                    best_sz = sz;
                    found = 1;
                    if (policy == hba_pkg::FIT_FIRST) break;
                end
            end
            last = h;
            h = next_hdr(h);
        end
        if (found) begin
            if (best_sz - req >= hba_pkg::HEADER_WORDS + 1) begin
                r = best + hba_pkg::HEADER_WORDS + req;
                blk_size[best] = req;
                blk_size[r] = best_sz - req - hba_pkg::HEADER_WORDS;
                blk_free[r] = 1;
                blk_prev[r] = best;
                relink(r);
            end
            blk_free[best] = 0;
            g.granted = hba_pkg::ADDR_W'(best + hba_pkg::HEADER_WORDS);
            return g;
        end
        if (top_mark + hba_pkg::HEADER_WORDS + req > hba_pkg::HEAP_WORDS ||
            top_mark >= hba_pkg::HEAP_WORDS) begin
            g.status = hba_pkg::ST_FAIL;
            return g;
        end
        h = top_mark;
        blk_size[h] = req;
        blk_free[h] = 0;
        blk_prev[h] = last;
        top_mark = h + hba_pkg::HEADER_WORDS + req;
        g.granted = hba_pkg::ADDR_W'(h + hba_pkg::HEADER_WORDS);
        return g;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n) begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == hba_pkg::REG_FIT_POLICY)
                policy = i_pwdata[0];
            if (i_s_tvalid && i_s_tready) begin
                g = '0;
                if (i_s_tdata[0] == hba_pkg::ACT_ALLOC)
                    g = claim_block(int'(i_s_tdata[13:1]));
                else
                    release_block(int'(i_s_tdata[25:14]));
                grants_due.push_back(g);
            end
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (grants_due.size() == 0) begin
                    $display("unexpected item %h at %0t", i_m_tdata, $realtime);
                    o_errors++;
                end else begin
                    g = grants_due.pop_front();
                    if (i_m_tdata[11:0] != g.granted)
                        report("granted_address", i_m_tdata[11:0], g.granted);
                    if (i_m_tdata[12] != g.status)
                        report("status", i_m_tdata[12], g.status);
                end
            end
        end
    end
endmodule

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;  // action, request_words, block_address, zero fill
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [15:0] o_m_tdata;       // granted_address, status, zero fill
    logic        i_psel = 0;
    logic        i_penable = 0;
    logic        i_pwrite = 0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    int errors, pending, results;
    int send_idle = 0, take_idle = 0;
    int stall_go = 0;
    int quiet = 0;
    int sent = 0;
    logic [hba_pkg::ADDR_W-1:0] live[$];

    always #5 i_clk = ~i_clk;

    heap_block_allocator dut (.*);

    hba_checker u_checker (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata, .i_pready(o_pready),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // receiver side, with a long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_go) begin
                stall_go = 0;
                i_m_tready <= 0;
                repeat (3000) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= take_idle);
        end
    end

    // addresses handed out, for well-formed frees
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready && o_m_tdata[11:0] != 0) live.push_back(o_m_tdata[11:0]);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_psel) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send(logic act, int req, int addr);
        i_s_tvalid <= 1;
        i_s_tdata  <= {6'd0, 12'(addr), 13'(req), act};
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        if ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic set_policy(logic pol);
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_psel <= 1; i_pwrite <= 1; i_paddr <= hba_pkg::REG_FIT_POLICY;
        i_pwdata <= {31'd0, pol};
        @(posedge i_clk);
        i_penable <= 1;
        @(posedge i_clk);
        i_psel <= 0; i_penable <= 0; i_pwrite <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int r, sz, idx;
        r = $urandom_range(99);
        if (r < 50) begin
            sz = $urandom_range(99);
            if (sz < 90) sz = $urandom_range(48);
            else if (sz < 97) sz = $urandom_range(600, 49);
            else sz = $urandom_range(4096);
            send(hba_pkg::ACT_ALLOC, sz, $urandom_range(4095));
        end else if (r < 90 && live.size() != 0) begin
            idx = $urandom_range(live.size() - 1);
            send(hba_pkg::ACT_FREE, $urandom_range(8191), live[idx]);
            live.delete(idx);
        end else if (r < 95) begin
            send(hba_pkg::ACT_FREE, $urandom_range(8191), $urandom_range(4095));
        end else begin
            send(hba_pkg::ACT_FREE, $urandom_range(8191), 0);
        end
    endtask

    task automatic run_phase(int n_items, int s_idle, int t_idle, bit stall);
        send_idle = s_idle;
        take_idle = t_idle;
        for (int k = 0; k < n_items; k++) begin
            if (stall && k == n_items / 2) stall_go = 1;
            random_item();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        i_m_tready <= 1;
        @(posedge i_clk);
        set_policy(hba_pkg::FIT_FIRST);
        send(hba_pkg::ACT_ALLOC, 0, 0);
        send(hba_pkg::ACT_ALLOC, 5, 4095);
        send(hba_pkg::ACT_ALLOC, 10, 0);
        send(hba_pkg::ACT_ALLOC, 1, 0);
        send(hba_pkg::ACT_ALLOC, 20, 0);
        send(hba_pkg::ACT_FREE, 0, 0);
        send(hba_pkg::ACT_FREE, 0, 1);
        send(hba_pkg::ACT_FREE, 8191, 3);
        send(hba_pkg::ACT_FREE, 0, 3);
        send(hba_pkg::ACT_FREE, 0, 14);
        send(hba_pkg::ACT_FREE, 0, 6);
        send(hba_pkg::ACT_ALLOC, 2, 0);
        send(hba_pkg::ACT_ALLOC, 16, 0);
        send(hba_pkg::ACT_FREE, 0, 4095);
        send(hba_pkg::ACT_ALLOC, 4096, 0);
        send(hba_pkg::ACT_ALLOC, 4000, 0);
        send(hba_pkg::ACT_ALLOC, 50, 0);
        send(hba_pkg::ACT_FREE, 0, 31);
        send(hba_pkg::ACT_FREE, 0, 27);
        send(hba_pkg::ACT_ALLOC, 0, 0);
        set_policy(hba_pkg::FIT_BEST);
        run_phase(175, 31, 52, 0);
        set_policy(hba_pkg::FIT_FIRST);
        run_phase(175, 52, 31, 0);
        set_policy(hba_pkg::FIT_BEST);
        run_phase(175, 0, 0, 1);
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d items (allocs, frees, null and stray frees, oversize requests)",
                 sent);
        $display("under both fit policies with %0d results checked", results);
        if (errors == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/hba_pkg.sv
rtl/core/heap_block_allocator.sv
tb/sv/hba_checker.sv
tb/sv/testbench.sv
